FILE: hdl/abkf_pkg.sv
// Shared types and codes for the angle and gyro-bias Kalman filter.
package abkf_pkg;

  typedef enum logic [4:0] {
    S_IDLE, S_RATE, S_M1, S_M2, S_M3, S_M4, S_CHK, S_DIV1, S_DIV2,
    S_M5, S_M6, S_M7, S_M8, S_M9, S_M10, S_FIN
  } state_t;

  localparam logic [1:0] STATUS_OK   = 2'd0;
  localparam logic [1:0] STATUS_SAT  = 2'd1;
  localparam logic [1:0] STATUS_SKIP = 2'd2;

  localparam logic [1:0] REG_ANGLE_NOISE = 2'd0;
  localparam logic [1:0] REG_BIAS_NOISE  = 2'd1;
  localparam logic [1:0] REG_MEAS_NOISE  = 2'd2;

  localparam int DT_FRAC    = 24;
  localparam int NOISE_FRAC = 24;

endpackage

FILE: hdl/angle_bias_kalman_filter.sv
// Two-state Kalman filter: angle and gyro-bias estimate from angle and rate words.
// One input word is taken in the idle state. Ten products go through one shared
// multiplier, one per cycle, and the two gains come from a restoring divider that
// yields one quotient bit per cycle. A skipped correction (P00+R not positive) goes
// from the check state straight to the finish state. The result sits in an output
// register, so the next word is accepted while it waits to be taken.
module angle_bias_kalman_filter #(
  parameter int WORD_WIDTH    = 32,
  parameter int COV_FRAC_BITS = 24
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [87:0] in_tdata,   // measured_angle, turn_rate, elapsed_time
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // angle_out, bias_out
  output logic [1:0]  out_tuser,  // status
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import abkf_pkg::*;

  localparam int W   = WORD_WIDTH;
  localparam int CF  = COV_FRAC_BITS;
  localparam int EW  = (W > 32 ? W : 32) + 8;
  localparam int OW  = W + 1;
  localparam int PW  = 2 * OW;
  localparam int NB  = W + CF;
  localparam int CW  = $clog2(NB + 1);
  localparam int SHL = (CF >= NOISE_FRAC) ? CF - NOISE_FRAC : 0;
  localparam int SHR = (CF >= NOISE_FRAC) ? 0 : NOISE_FRAC - CF;

  localparam logic signed [EW-1:0] HI_E = {{(EW-W+1){1'b0}}, {(W-1){1'b1}}};
  localparam logic signed [EW-1:0] LO_E = ~HI_E;
  localparam logic signed [EW-1:0] H32  = {{(EW-31){1'b0}}, {31{1'b1}}};
  localparam logic signed [EW-1:0] L32  = ~H32;
  localparam logic [PW-1:0] MAXP = {{(PW-W+1){1'b0}}, {(W-1){1'b1}}};
  localparam logic [PW-1:0] MAXN = MAXP + PW'(1);
  localparam logic [W+1:0]  MAXPQ = {3'b000, {(W-1){1'b1}}};
  localparam logic [W+1:0]  MAXNQ = MAXPQ + (W+2)'(1);
  localparam logic signed [W-1:0] HI_W = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] LO_W = ~HI_W;

  function automatic logic [W:0] sat_w(input logic signed [EW-1:0] v);
    logic [W:0] r;
    if (v > HI_E) r = {1'b1, HI_E[W-1:0]};
    else if (v < LO_E) r = {1'b1, LO_E[W-1:0]};
    else r = {1'b0, v[W-1:0]};
    return r;
  endfunction

  function automatic logic [W:0] nconv(input logic signed [31:0] v);
    logic signed [EW-1:0] t;
    t = EW'(v) <<< SHL;
    if (t < 0) t = (t + EW'((64'd1 << SHR) - 64'd1)) >>> SHR;
    else t = t >>> SHR;
    return sat_w(t);
  endfunction

  state_t state_r, state_nxt;
  logic signed [31:0] meas_r, meas_nxt, rate_r, rate_nxt;
  logic [23:0] dt_r, dt_nxt;
  logic signed [W-1:0] ang_r, ang_nxt, bias_r, bias_nxt;
  logic signed [W-1:0] p00_r, p00_nxt, p01_r, p01_nxt, p10_r, p10_nxt, p11_r, p11_nxt;
  logic signed [W-1:0] q00_r, q00_nxt, q01_r, q01_nxt, q10_r, q10_nxt, q11_r, q11_nxt;
  logic signed [W-1:0] ap_r, ap_nxt, tmp_r, tmp_nxt, y_r, y_nxt;
  logic signed [W-1:0] k1_r, k1_nxt, k2_r, k2_nxt;
  logic signed [EW-1:0] acc_r, acc_nxt;
  logic signed [W+1:0] den_r, den_nxt, den_w;
  logic clip_r, clip_nxt, skip_r, skip_nxt;
  logic signed [31:0] qa_r, qa_nxt, qb_r, qb_nxt;
  logic [30:0] rn_r, rn_nxt;
  logic [NB-1:0] dsh_r, dsh_nxt;
  logic [W:0] rem_r, rem_nxt, quo_r, quo_nxt;
  logic ovf_r, ovf_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic out_valid_r, out_valid_nxt;
  logic [63:0] out_data_r, out_data_nxt;
  logic [1:0] out_user_r, out_user_nxt;

  logic signed [OW-1:0] ma, mb;
  logic msh_cf;
  logic [OW-1:0] amag, bmag;
  logic [PW-1:0] prod, pm;
  logic mneg, mclip;
  logic signed [W-1:0] mres;
  logic [W:0] nq, nb, nr;
  logic in_acc, cfg_wr, div_last, out_free;

  assign in_tready  = (state_r == S_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign div_last   = (cnt_r == CW'(NB - 1));
  assign out_free   = !out_valid_r || out_tready;

  assign nq = nconv(qa_r);
  assign nb = nconv(qb_r);
  assign nr = nconv({1'b0, rn_r});
  assign den_w = (W+2)'(q00_r) + (W+2)'($signed(nr[W-1:0]));

  always_comb begin
    case (cfg_paddr[3:2])
      REG_ANGLE_NOISE: cfg_prdata = qa_r;
      REG_BIAS_NOISE:  cfg_prdata = qb_r;
      REG_MEAS_NOISE:  cfg_prdata = {1'b0, rn_r};
      default:         cfg_prdata = 32'd0;
    endcase
  end

  // shared multiplier: (a*b) >> shift, truncated toward zero, saturated
  always_comb begin
    amag  = ma[OW-1] ? OW'(-ma) : OW'(ma);
    bmag  = mb[OW-1] ? OW'(-mb) : OW'(mb);
    prod  = PW'(amag) * PW'(bmag);
    pm    = msh_cf ? (prod >> CF) : (prod >> DT_FRAC);
    mneg  = ma[OW-1] ^ mb[OW-1];
    mclip = 1'b0;
    if (!mneg) begin
      if (pm > MAXP) begin mclip = 1'b1; mres = HI_W; end
      else mres = pm[W-1:0];
    end else begin
      if (pm > MAXN) begin mclip = 1'b1; mres = LO_W; end
      else mres = -$signed(pm[W-1:0]);
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (in_acc) state_nxt = S_RATE;
      S_RATE: state_nxt = S_M1;
      S_M1:   state_nxt = S_M2;
      S_M2:   state_nxt = S_M3;
      S_M3:   state_nxt = S_M4;
      S_M4:   state_nxt = S_CHK;
      S_CHK:  state_nxt = (den_w <= 0) ? S_FIN : S_DIV1;
      S_DIV1: if (div_last) state_nxt = S_DIV2;
      S_DIV2: if (div_last) state_nxt = S_M5;
      S_M5:   state_nxt = S_M6;
      S_M6:   state_nxt = S_M7;
      S_M7:   state_nxt = S_M8;
      S_M8:   state_nxt = S_M9;
      S_M9:   state_nxt = S_M10;
      S_M10:  state_nxt = S_FIN;
      S_FIN:  if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    logic [W:0] s0, s1, s2;
    logic [W+1:0] r2, fm;
    logic qb_bit, fo, sgn;
    logic signed [W-1:0] kv;
    logic kc;
    logic signed [EW-1:0] e;
    logic [31:0] ao, bo;
    logic c32;

    meas_nxt = meas_r; rate_nxt = rate_r; dt_nxt = dt_r;
    ang_nxt = ang_r; bias_nxt = bias_r;
    p00_nxt = p00_r; p01_nxt = p01_r; p10_nxt = p10_r; p11_nxt = p11_r;
    q00_nxt = q00_r; q01_nxt = q01_r; q10_nxt = q10_r; q11_nxt = q11_r;
    ap_nxt = ap_r; tmp_nxt = tmp_r; y_nxt = y_r; k1_nxt = k1_r; k2_nxt = k2_r;
    acc_nxt = acc_r; den_nxt = den_r; clip_nxt = clip_r; skip_nxt = skip_r;
    qa_nxt = qa_r; qb_nxt = qb_r; rn_nxt = rn_r;
    dsh_nxt = dsh_r; rem_nxt = rem_r; quo_nxt = quo_r; ovf_nxt = ovf_r; cnt_nxt = cnt_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt = out_data_r; out_user_nxt = out_user_r;
    ma = '0; mb = '0; msh_cf = 1'b0;
    s0 = '0; s1 = '0; s2 = '0;
    r2 = {rem_r, dsh_r[NB-1]};
    qb_bit = (r2 >= $unsigned(den_r));
    fo = ovf_r | quo_r[W];
    fm = {fo, quo_r[W-1:0], qb_bit};
    sgn = (state_r == S_DIV1) ? q00_r[W-1] : q10_r[W-1];
    kc = 1'b0; kv = '0;
    if (!sgn) begin
      if (fm > MAXPQ) begin kc = 1'b1; kv = HI_W; end
      else kv = fm[W-1:0];
    end else begin
      if (fm > MAXNQ) begin kc = 1'b1; kv = LO_W; end
      else kv = -$signed(fm[W-1:0]);
    end
    e = EW'(ang_r); ao = e[31:0]; c32 = 1'b0;
    if (e > H32) begin ao = H32[31:0]; c32 = 1'b1; end
    else if (e < L32) begin ao = L32[31:0]; c32 = 1'b1; end
    e = EW'(bias_r); bo = e[31:0];
    if (e > H32) begin bo = H32[31:0]; c32 = 1'b1; end
    else if (e < L32) begin bo = L32[31:0]; c32 = 1'b1; end

    if (cfg_wr) begin
      case (cfg_paddr[3:2])
        REG_ANGLE_NOISE: qa_nxt = cfg_pwdata;
        REG_BIAS_NOISE:  qb_nxt = cfg_pwdata;
        REG_MEAS_NOISE:  rn_nxt = cfg_pwdata[30:0];
        default: ;
      endcase
    end

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          meas_nxt = in_tdata[31:0];
          rate_nxt = in_tdata[63:32];
          dt_nxt   = in_tdata[87:64];
          clip_nxt = 1'b0;
          skip_nxt = 1'b0;
        end
      end
      S_RATE: begin
        s0 = sat_w(EW'(rate_r) - EW'(bias_r));
        tmp_nxt = s0[W-1:0]; clip_nxt = clip_r | s0[W];
      end
      S_M1: begin
        ma = OW'(tmp_r); mb = OW'({1'b0, dt_r});
        s0 = sat_w(EW'(ang_r) + EW'(mres));
        ap_nxt = s0[W-1:0]; clip_nxt = clip_r | s0[W] | mclip;
      end
      S_M2: begin
        s0 = sat_w(EW'(p01_r) + EW'(p10_r));
        ma = OW'($signed(s0[W-1:0])); mb = OW'({1'b0, dt_r});
        acc_nxt = EW'(p00_r) - EW'(mres);
        clip_nxt = clip_r | s0[W] | mclip;
      end
      S_M3: begin
        ma = OW'(p11_r); mb = OW'({1'b0, dt_r});
        tmp_nxt = mres;
        s0 = sat_w(EW'(p01_r) - EW'(mres));
        s1 = sat_w(EW'(p10_r) - EW'(mres));
        q01_nxt = s0[W-1:0]; q10_nxt = s1[W-1:0];
        clip_nxt = clip_r | s0[W] | s1[W] | mclip;
      end
      S_M4: begin
        ma = OW'(tmp_r); mb = OW'({1'b0, dt_r});
        s0 = sat_w(acc_r + EW'(mres) + EW'($signed(nq[W-1:0])));
        s1 = sat_w(EW'(p11_r) + EW'($signed(nb[W-1:0])));
        q00_nxt = s0[W-1:0]; q11_nxt = s1[W-1:0];
        clip_nxt = clip_r | s0[W] | s1[W] | mclip | nq[W] | nb[W];
      end
      S_CHK: begin
        s2 = sat_w(EW'(meas_r) - EW'(ap_r));
        y_nxt = s2[W-1:0];
        den_nxt = den_w;
        clip_nxt = clip_r | nr[W] | s2[W];
        if (den_w <= 0) begin
          ang_nxt = ap_r;
          p00_nxt = q00_r; p01_nxt = q01_r; p10_nxt = q10_r; p11_nxt = q11_r;
          skip_nxt = 1'b1;
        end
        dsh_nxt = {(q00_r[W-1] ? W'(-q00_r) : W'(q00_r)), {CF{1'b0}}};
        rem_nxt = '0; quo_nxt = '0; ovf_nxt = 1'b0; cnt_nxt = '0;
      end
      S_DIV1, S_DIV2: begin
        rem_nxt = qb_bit ? W'(r2 - $unsigned(den_r)) + (W+1)'(0) : r2[W:0];
        quo_nxt = {quo_r[W-1:0], qb_bit};
        ovf_nxt = fo;
        dsh_nxt = dsh_r << 1;
        cnt_nxt = cnt_r + CW'(1);
        if (div_last) begin
          clip_nxt = clip_r | kc;
          cnt_nxt = '0; rem_nxt = '0; quo_nxt = '0; ovf_nxt = 1'b0;
          if (state_r == S_DIV1) begin
            k1_nxt = kv;
            dsh_nxt = {(q10_r[W-1] ? W'(-q10_r) : W'(q10_r)), {CF{1'b0}}};
          end else begin
            k2_nxt = kv;
          end
        end
      end
      S_M5: begin
        ma = OW'(k1_r); mb = OW'(y_r); msh_cf = 1'b1;
        s0 = sat_w(EW'(ap_r) + EW'(mres));
        ang_nxt = s0[W-1:0]; clip_nxt = clip_r | s0[W] | mclip;
      end
      S_M6: begin
        ma = OW'(k2_r); mb = OW'(y_r); msh_cf = 1'b1;
        s0 = sat_w(EW'(bias_r) + EW'(mres));
        bias_nxt = s0[W-1:0]; clip_nxt = clip_r | s0[W] | mclip;
      end
      S_M7: begin
        ma = OW'(k1_r); mb = OW'(q00_r); msh_cf = 1'b1;
        s0 = sat_w(EW'(q00_r) - EW'(mres));
        p00_nxt = s0[W-1:0]; clip_nxt = clip_r | s0[W] | mclip;
      end
      S_M8: begin
        ma = OW'(k1_r); mb = OW'(q01_r); msh_cf = 1'b1;
        s0 = sat_w(EW'(q01_r) - EW'(mres));
        p01_nxt = s0[W-1:0]; clip_nxt = clip_r | s0[W] | mclip;
      end
      S_M9: begin
        ma = OW'(k2_r); mb = OW'(q00_r); msh_cf = 1'b1;
        s0 = sat_w(EW'(q10_r) - EW'(mres));
        p10_nxt = s0[W-1:0]; clip_nxt = clip_r | s0[W] | mclip;
      end
      S_M10: begin
        ma = OW'(k2_r); mb = OW'(q01_r); msh_cf = 1'b1;
        s0 = sat_w(EW'(q11_r) - EW'(mres));
        p11_nxt = s0[W-1:0]; clip_nxt = clip_r | s0[W] | mclip;
      end
      S_FIN: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt = {bo, ao};
          if (skip_r) out_user_nxt = STATUS_SKIP;
          else if (clip_r || c32) out_user_nxt = STATUS_SAT;
          else out_user_nxt = STATUS_OK;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      ang_r       <= '0;
      bias_r      <= '0;
      p00_r       <= W'(64'd1 << CF);
      p01_r       <= '0;
      p10_r       <= '0;
      p11_r       <= W'(64'd1 << CF);
      qa_r        <= 32'sd16777;
      qb_r        <= -32'sd1678;
      rn_r        <= 31'd8388608;
      clip_r      <= 1'b0;
      skip_r      <= 1'b0;
      cnt_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      ang_r       <= ang_nxt;
      bias_r      <= bias_nxt;
      p00_r       <= p00_nxt;
      p01_r       <= p01_nxt;
      p10_r       <= p10_nxt;
      p11_r       <= p11_nxt;
      qa_r        <= qa_nxt;
      qb_r        <= qb_nxt;
      rn_r        <= rn_nxt;
      clip_r      <= clip_nxt;
      skip_r      <= skip_nxt;
      cnt_r       <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    meas_r <= meas_nxt; rate_r <= rate_nxt; dt_r <= dt_nxt;
    q00_r <= q00_nxt; q01_r <= q01_nxt; q10_r <= q10_nxt; q11_r <= q11_nxt;
    ap_r <= ap_nxt; tmp_r <= tmp_nxt; y_r <= y_nxt; k1_r <= k1_nxt; k2_r <= k2_nxt;
    acc_r <= acc_nxt; den_r <= den_nxt;
    dsh_r <= dsh_nxt; rem_r <= rem_nxt; quo_r <= quo_nxt; ovf_r <= ovf_nxt;
    out_data_r <= out_data_nxt; out_user_r <= out_user_nxt;
  end

endmodule
